// ===== design/pcp_pkg.sv =====
// Shared types and constants for the point-in-convex-polygon test unit.
// No dependencies; imported by pcp_front, pcp_back and the top level.
`default_nettype none

package pcp_pkg;

    localparam int COORD_W          = 32;
    localparam int MAX_VERTICES_DEF = 16;

    // Fixed-point shifts of the edge test and the tolerance scaling
    localparam int TOL_SHIFT   = 7;
    localparam int FRAC_SHIFT  = 12;
    localparam int CROSS_SHIFT = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes of the input beat
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_TEST   = 1'b1;

    typedef enum logic {
        CMD_APPEND,
        CMD_TEST
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic signed [COORD_W-1:0] margin;
    } item_t;

    typedef struct packed {
        logic inside_res;
        logic overflowed;
    } result_t;

    // Classified command handed from front to back
    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] tol;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vtx_t;

endpackage

`default_nettype wire

// ===== design/point_in_convex_polygon_test_unit.sv =====
// Top level of the point-in-convex-polygon test unit: front end with its
// queue feeding the back end. Depends on pcp_pkg, pcp_front and pcp_back.
//
//   channel   handshake                    beat
//   item      item_valid / item_ready      pcp_pkg::item_t   (vertex or test point)
//   result    result_valid / result_ready  pcp_pkg::result_t (one per test)
//
// A test of a polygon with n stored vertices walks n + 1 reads through the
// single read port of the vertex store, then the difference, multiply and
// sum stages; with no vertices stored it skips the walk. The front queue
// holds two beats, so input is taken while the back end walks or while a
// result waits to be taken. Reset clears the vertex count, the drop flag
// and all handshakes.
`default_nettype none

module point_in_convex_polygon_test_unit #(
    parameter int MAX_VERTICES = pcp_pkg::MAX_VERTICES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire pcp_pkg::item_t item,
    output logic                result_valid,
    input  wire logic           result_ready,
    output pcp_pkg::result_t    result
);
    import pcp_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    pcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    pcp_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== design/pcp_front.sv =====
// Front end: accepts input beats, classifies them and scales the tolerance,
// then holds them in a short queue for the back end. Depends on pcp_pkg.
`default_nettype none

module pcp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire pcp_pkg::item_t item,
    output logic                cmd_valid,
    input  wire logic           cmd_ready,
    output pcp_pkg::cmd_t       cmd
);
    import pcp_pkg::*;

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push, pop;
    cmd_t              cmd_in;

    always_comb
    begin
        cmd_in.kind = (item.operation == OP_TEST) ? CMD_TEST : CMD_APPEND;
        cmd_in.x    = item.coord_x;
        cmd_in.y    = item.coord_y;
        cmd_in.z    = item.coord_z;
        cmd_in.tol  = item.margin <<< TOL_SHIFT;
    end

    assign item_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid  = (fill_reg != '0);
    assign cmd        = q_mem_reg[rd_ptr_reg];
    assign push       = item_valid & item_ready;
    assign pop        = cmd_valid & cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/pcp_back.sv =====
// Back end: vertex store, z window check and a pipelined cross-product edge
// walk, with the result register. Depends on pcp_pkg.
`default_nettype none

module pcp_back #(
    parameter int MAX_VERTICES = pcp_pkg::MAX_VERTICES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire pcp_pkg::cmd_t cmd,
    output logic               result_valid,
    input  wire logic          result_ready,
    output pcp_pkg::result_t   result
);
    import pcp_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    back_state_t state_reg, state_next;

    vtx_t                      mem [MAX_VERTICES];
    logic [CW-1:0]             count_reg;
    logic                      dropped_reg;
    logic signed [COORD_W-1:0] zlast_reg, zmax_reg, zmin_reg;

    logic [CW-1:0]             n_reg, idx_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, tol_reg;
    logic                      ovf_reg, fail_reg;

    vtx_t                      rdq_reg, prev_reg;
    logic                      rd_v_reg, rd_first_reg, rd_last_reg;
    logic signed [COORD_W-1:0] ea_reg, eb_reg, ec_reg, ed_reg;
    logic                      d_v_reg, d_last_reg;
    logic signed [COORD_W-1:0] p1_reg, p2_reg;
    logic                      m_v_reg, m_last_reg;

    logic                      out_valid_reg;
    result_t                   out_data_reg;

    logic                      take, do_append, do_test, has_room;
    logic                      rd_en, out_load, edge_neg, z_fail;
    logic [AW-1:0]             rd_addr;
    logic signed [COORD_W-1:0] zhi, zlo, lo_bound, hi_bound;
    logic signed [COORD_W-1:0] dy_p, dx_e, dx_p, dy_e, s_sum;

    assign take      = cmd_valid & cmd_ready;
    assign do_append = take & (cmd.kind == CMD_APPEND);
    assign do_test   = take & (cmd.kind == CMD_TEST);
    assign has_room  = (count_reg < CW'(MAX_VERTICES));

    // z window from the last stored edge; zero bounds below two vertices
    always_comb
    begin
        zhi      = (count_reg > CW'(1)) ? zmax_reg : '0;
        zlo      = (count_reg > CW'(1)) ? zmin_reg : '0;
        lo_bound = cmd.z - cmd.tol;
        hi_bound = cmd.z + cmd.tol;
        z_fail   = (zhi < lo_bound) || (hi_bound < zlo);
    end

    // Wrap back to vertex 0 after the last one
    assign rd_addr = (idx_reg == n_reg) ? '0 : idx_reg[AW-1:0];

    always_comb
    begin
        dy_p  = (py_reg - prev_reg.y) >>> FRAC_SHIFT;
        dx_e  = (rdq_reg.x - prev_reg.x) >>> FRAC_SHIFT;
        dx_p  = (px_reg - prev_reg.x) >>> FRAC_SHIFT;
        dy_e  = (rdq_reg.y - prev_reg.y) >>> FRAC_SHIFT;
        s_sum = ((p1_reg - p2_reg) <<< CROSS_SHIFT) + tol_reg;
        edge_neg = m_v_reg & s_sum[COORD_W-1];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_TEST)
                begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (m_v_reg && m_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  cmd_ready = 1'b1;
            ST_WALK:  rd_en     = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  out_load  = ~out_valid_reg | result_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            idx_reg       <= '0;
            rd_v_reg      <= 1'b0;
            d_v_reg       <= 1'b0;
            m_v_reg       <= 1'b0;
            m_last_reg    <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (do_test)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else if (do_append)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end

            if (do_test)
            begin
                idx_reg <= '0;
            end
            else if (rd_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            rd_v_reg   <= rd_en;
            d_v_reg    <= rd_v_reg & ~rd_first_reg;
            m_v_reg    <= d_v_reg;
            m_last_reg <= d_v_reg & d_last_reg;

            // Sticky failure: z window at start, then any negative edge sum
            if (do_test)
            begin
                fail_reg <= z_fail;
            end
            else if (edge_neg)
            begin
                fail_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and vertex store
    always_ff @(posedge clk)
    begin
        if (do_append && has_room)
        begin
            mem[count_reg[AW-1:0]] <= '{x: cmd.x, y: cmd.y};
            zlast_reg <= cmd.z;
            if (count_reg != '0)
            begin
                zmax_reg <= (cmd.z < zlast_reg) ? zlast_reg : cmd.z;
                zmin_reg <= (cmd.z < zlast_reg) ? cmd.z : zlast_reg;
            end
        end

        if (do_test)
        begin
            n_reg   <= count_reg;
            px_reg  <= cmd.x;
            py_reg  <= cmd.y;
            tol_reg <= cmd.tol;
            ovf_reg <= dropped_reg;
        end

        if (rd_en)
        begin
            rdq_reg      <= mem[rd_addr];
            rd_first_reg <= (idx_reg == '0);
            rd_last_reg  <= (idx_reg == n_reg);
        end

        // Edge (prev, current): differences, then products
        if (rd_v_reg)
        begin
            prev_reg   <= rdq_reg;
            ea_reg     <= dy_p;
            eb_reg     <= dx_e;
            ec_reg     <= dx_p;
            ed_reg     <= dy_e;
            d_last_reg <= rd_last_reg;
        end

        p1_reg <= ea_reg * eb_reg;
        p2_reg <= ec_reg * ed_reg;

        if (out_load)
        begin
            out_data_reg.inside_res <= ~fail_reg;
            out_data_reg.overflowed <= ovf_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

`default_nettype wire
